>>> src/pid_pkg.sv
// Shared widths, types, register indexes and helpers for the PID step block.
package pid_pkg;

  localparam int DATA_W    = 32;
  localparam int DIV_NUM_W = DATA_W + 1;
  localparam int MUL_W     = DATA_W + 2;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int ACC_W     = 64;
  localparam int SUM_W     = DATA_W + 4;
  localparam int PM_W      = DATA_W + 2;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [DATA_W-1:0]    data_t;
  typedef logic signed [DIV_NUM_W-1:0] quo_t;
  typedef logic signed [MUL_W-1:0]     mul_op_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [ACC_W-1:0]     acc_t;
  typedef logic signed [SUM_W-1:0]     sum_t;
  typedef logic [CFG_IDX_W-1:0]        cfg_idx_t;

  localparam cfg_idx_t REG_GAIN_P     = 3'd0;
  localparam cfg_idx_t REG_GAIN_I     = 3'd1;
  localparam cfg_idx_t REG_GAIN_D     = 3'd2;
  localparam cfg_idx_t REG_BIAS       = 3'd3;
  localparam cfg_idx_t REG_WINDOW     = 3'd4;
  localparam cfg_idx_t REG_INT_LOW    = 3'd5;
  localparam cfg_idx_t REG_INT_HIGH   = 3'd6;
  localparam cfg_idx_t REG_CLEAR_SIGN = 3'd7;

  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam data_t DATA_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t DATA_MIN   = {1'b1, {(DATA_W-1){1'b0}}};
  localparam data_t WINDOW_OFF = '1;

  // Ceiling of one integration increment in magnitude.
  localparam prod_t PM_LIMIT = prod_t'(1) <<< (DATA_W + 1);

  typedef struct packed {
    logic start;
    quo_t num;
    logic [DATA_W-1:0] den;
  } div_req_t;

  function automatic data_t sat_data(input acc_t v);
    if (v[ACC_W-1:DATA_W-1] == {(ACC_W-DATA_W+1){v[ACC_W-1]}}) begin
      return v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      return DATA_MIN;
    end else begin
      return DATA_MAX;
    end
  endfunction

endpackage

>>> src/pid_controller_step.sv
// PID control step: sequencer and datapath around a shared multiplier and serial divider.
//
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   in_opcode, in_measured, in_target, in_time_ms
// out      output     out_valid / out_ready out_command, out_error_out
// cfg      input      cfg_we                cfg_index, cfg_wdata
//
// A control step's length is set by the 32-step serial derivative divide
// that runs beside the shared multiplier; a clear transfer returns its result in the cycle after it is taken.
// The next input transfer is taken once the result register has been emptied.
// Reset is synchronous and returns configuration, stored history, output valid and controller state to their defaults.
// A stalled output holds its result and keeps the input side waiting.
module pid_controller_step
  import pid_pkg::*;
#(
  parameter int FRAC_BITS = 16
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_opcode,
  input  data_t             in_measured,
  input  data_t             in_target,
  input  logic [DATA_W-1:0] in_time_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output data_t             out_command,
  output data_t             out_error_out,
  input  logic              cfg_we,
  input  cfg_idx_t          cfg_index,
  input  logic [DATA_W-1:0] cfg_wdata
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_ERR      = 4'd1;
  localparam logic [3:0] ST_MUL_I    = 4'd2;
  localparam logic [3:0] ST_RATE     = 4'd3;
  localparam logic [3:0] ST_MUL_PM   = 4'd4;
  localparam logic [3:0] ST_INTEG    = 4'd5;
  localparam logic [3:0] ST_CLAMP    = 4'd6;
  localparam logic [3:0] ST_WAIT_DIV = 4'd7;
  localparam logic [3:0] ST_ADD_D    = 4'd8;
  localparam logic [3:0] ST_BIAS     = 4'd9;
  localparam logic [3:0] ST_DONE     = 4'd10;

  data_t gain_p_r, gain_i_r, gain_d_r, bias_r, window_r, int_low_r, int_high_r;
  logic  clear_sign_r;

  data_t             integral_sum_r;
  logic [DATA_W-1:0] prev_time_r;
  data_t             prev_meas_r;
  data_t             prev_err_r;

  logic [3:0]        state_r, state_nxt;
  data_t             measured_r, target_r;
  logic [DATA_W-1:0] time_r;
  data_t             err_r;
  logic [DATA_W-1:0] dt_r;
  logic              first_r, dt_nz_r, win_ok_r, sign_chg_r;
  logic              rate_neg_r, big_r;
  logic [DATA_W:0]   mag_r;
  sum_t              sum_r;
  data_t             integ_r;
  acc_t              acc_r;
  logic              out_valid_r;
  data_t             out_command_r, out_error_r;

  logic              in_xfer;
  logic              out_xfer;
  logic              mul_en;
  mul_op_t           mul_a, mul_b;
  prod_t             prod;
  prod_t             prod_sh;
  prod_t             rate_mag;
  logic              div_done;
  quo_t              div_quo;
  div_req_t          div_req;
  logic [DATA_W:0]   err_diff;
  data_t             err_sat;
  logic [DATA_W:0]   err_mag;
  mul_op_t           deriv;
  logic              pm_sat;
  logic [PM_W-1:0]   pm;
  sum_t              pm_signed;
  data_t             clamp_v0, clamp_v1, clamp_v2, clamp_v3;
  logic [DATA_W:0]   bias_mag;
  acc_t              bias_term;

  assign in_ready      = (state_r == ST_IDLE) && !out_valid_r;
  assign in_xfer       = in_valid && in_ready;
  assign out_xfer      = out_valid_r && out_ready;
  assign out_valid     = out_valid_r;
  assign out_command   = out_command_r;
  assign out_error_out = out_error_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r     <= '0;
      gain_i_r     <= '0;
      gain_d_r     <= '0;
      bias_r       <= '0;
      window_r     <= WINDOW_OFF;
      int_low_r    <= DATA_MIN;
      int_high_r   <= DATA_MAX;
      clear_sign_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_P:     gain_p_r     <= cfg_wdata;
        REG_GAIN_I:     gain_i_r     <= cfg_wdata;
        REG_GAIN_D:     gain_d_r     <= cfg_wdata;
        REG_BIAS:       bias_r       <= cfg_wdata;
        REG_WINDOW:     window_r     <= cfg_wdata;
        REG_INT_LOW:    int_low_r    <= cfg_wdata;
        REG_INT_HIGH:   int_high_r   <= cfg_wdata;
        REG_CLEAR_SIGN: clear_sign_r <= cfg_wdata[0];
        default:        clear_sign_r <= clear_sign_r;
      endcase
    end
  end

  assign err_diff = {target_r[DATA_W-1], target_r} - {measured_r[DATA_W-1], measured_r};
  assign err_sat  = (err_diff[DATA_W] != err_diff[DATA_W-1]) ?
                    (err_diff[DATA_W] ? DATA_MIN : DATA_MAX) : err_diff[DATA_W-1:0];
  assign err_mag  = err_r[DATA_W-1] ? -{err_r[DATA_W-1], err_r} : {err_r[DATA_W-1], err_r};

  assign div_req.start = (state_r == ST_ERR);
  assign div_req.num   = {prev_meas_r[DATA_W-1], prev_meas_r} -
                         {measured_r[DATA_W-1], measured_r};
  assign div_req.den   = time_r - prev_time_r;

  pid_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  assign deriv = (first_r || !dt_nz_r) ? '0 : MUL_W'(div_quo);

  always_comb begin
    mul_en = 1'b1;
    mul_a  = MUL_W'(gain_p_r);
    mul_b  = MUL_W'(err_r);
    unique case (state_r)
      ST_MUL_I: begin
        mul_a = MUL_W'(gain_i_r);
      end
      ST_RATE: begin
        mul_a = MUL_W'(gain_p_r);
      end
      ST_MUL_PM: begin
        mul_a = $signed({1'b0, mag_r});
        mul_b = $signed({2'b00, dt_r});
      end
      ST_WAIT_DIV: begin
        mul_a = MUL_W'(gain_d_r);
        mul_b = deriv;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  pid_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .op_a(mul_a),
    .op_b(mul_b),
    .prod(prod)
  );

  assign prod_sh  = prod >>> FRAC_BITS;
  assign rate_mag = prod_sh[PROD_W-1] ? -prod_sh : prod_sh;

  assign pm_sat    = (big_r && dt_nz_r) || (prod > PM_LIMIT);
  assign pm        = pm_sat ? PM_W'(PM_LIMIT) : prod[PM_W-1:0];
  assign pm_signed = (!first_r && win_ok_r) ?
                     (rate_neg_r ? -$signed({2'b00, pm}) : $signed({2'b00, pm})) : '0;

  assign clamp_v0 = sat_data(ACC_W'(sum_r));
  assign clamp_v1 = (clear_sign_r && sign_chg_r) ? '0 : clamp_v0;
  assign clamp_v2 = (clamp_v1 < int_low_r) ? int_low_r : clamp_v1;
  assign clamp_v3 = (clamp_v2 > int_high_r) ? int_high_r : clamp_v2;

  assign bias_mag  = bias_r[DATA_W-1] ? -{bias_r[DATA_W-1], bias_r} : {bias_r[DATA_W-1], bias_r};
  assign bias_term = err_r[DATA_W-1] ? -ACC_W'($signed({1'b0, bias_mag})) :
                     ACC_W'($signed({1'b0, bias_mag}));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_opcode == OP_STEP) begin
          state_nxt = ST_ERR;
        end
      end
      ST_ERR:      state_nxt = ST_MUL_I;
      ST_MUL_I:    state_nxt = ST_RATE;
      ST_RATE:     state_nxt = ST_MUL_PM;
      ST_MUL_PM:   state_nxt = ST_INTEG;
      ST_INTEG:    state_nxt = ST_CLAMP;
      ST_CLAMP:    state_nxt = ST_WAIT_DIV;
      ST_WAIT_DIV: begin
        if (div_done) begin
          state_nxt = ST_ADD_D;
        end
      end
      ST_ADD_D:    state_nxt = ST_BIAS;
      ST_BIAS:     state_nxt = ST_DONE;
      ST_DONE:     state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      integral_sum_r <= '0;
      prev_time_r    <= '0;
      prev_meas_r    <= '0;
      prev_err_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
      if (in_xfer && in_opcode == OP_CLEAR) begin
        integral_sum_r <= '0;
        prev_time_r    <= '0;
        prev_meas_r    <= '0;
        prev_err_r     <= '0;
        out_valid_r    <= 1'b1;
      end else if (state_r == ST_DONE) begin
        integral_sum_r <= integ_r;
        prev_time_r    <= time_r;
        prev_meas_r    <= measured_r;
        prev_err_r     <= err_r;
        out_valid_r    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      measured_r    <= in_measured;
      target_r      <= in_target;
      time_r        <= in_time_ms;
      out_command_r <= '0;
      out_error_r   <= '0;
    end
    unique case (state_r)
      ST_ERR: begin
        err_r   <= err_sat;
        dt_r    <= time_r - prev_time_r;
        first_r <= (prev_time_r == '0);
        dt_nz_r <= (time_r != prev_time_r);
        acc_r   <= '0;
      end
      ST_MUL_I: begin
        win_ok_r   <= (window_r == WINDOW_OFF) ||
                      ($signed({1'b0, err_mag}) <= $signed({window_r[DATA_W-1], window_r}));
        sign_chg_r <= err_r[DATA_W-1] != prev_err_r[DATA_W-1];
      end
      ST_RATE: begin
        rate_neg_r <= prod_sh[PROD_W-1];
        big_r      <= |rate_mag[PROD_W-1:DATA_W+1];
        mag_r      <= rate_mag[DATA_W:0];
      end
      ST_MUL_PM: begin
        acc_r <= acc_r + ACC_W'(prod_sh);
      end
      ST_INTEG: begin
        sum_r <= SUM_W'(integral_sum_r) + pm_signed;
      end
      ST_CLAMP: begin
        integ_r <= clamp_v3;
      end
      ST_WAIT_DIV: begin
        if (div_done) begin
          acc_r <= acc_r + ACC_W'(integ_r);
        end
      end
      ST_ADD_D: begin
        acc_r <= acc_r + ACC_W'(prod_sh);
      end
      ST_BIAS: begin
        acc_r <= acc_r + bias_term;
      end
      ST_DONE: begin
        out_command_r <= sat_data(acc_r);
        out_error_r   <= err_r;
      end
      default: begin
        acc_r <= acc_r;
      end
    endcase
  end

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_opcode == OP_CLEAR) |=>
      (out_valid && out_command == '0 && out_error_out == '0))
    else $error("clear transfer did not return a zero result");

  a_step_not_immediate: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_opcode == OP_STEP) |=> (!out_valid && state_r == ST_ERR))
    else $error("control step did not start its sequence");

  a_wait_divider: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT_DIV && !div_done) |=> (state_r == ST_WAIT_DIV))
    else $error("sequence left the divider wait early");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> (out_valid && !in_ready))
    else $error("finished step did not present its result");

endmodule

>>> src/pid_mul.sv
// Shared signed multiplier with a registered product.
module pid_mul
  import pid_pkg::*;
(
  input  logic    clk,
  input  logic    en,
  input  mul_op_t op_a,
  input  mul_op_t op_b,
  output prod_t   prod
);

  prod_t prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
    end
  end

  assign prod = prod_r;

endmodule

>>> src/pid_div.sv
// Restoring serial divider: signed dividend by unsigned divisor, quotient toward zero.
module pid_div
  import pid_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output logic     done,
  output quo_t     quo
);

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic              busy_r;
  logic              fix_r;
  logic              done_r;
  logic              neg_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] den_r;
  quo_t              quo_r;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;
  logic              take;
  quo_t              num_mag;

  assign num_mag = req.num[DIV_NUM_W-1] ? -req.num : req.num;
  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign take    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
    end else if (busy_r && cnt_r == CNT_W'(1)) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b1;
    end else if (fix_r) begin
      fix_r  <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_r <= req.num[DIV_NUM_W-1];
      quo_r <= num_mag;
      rem_r <= '0;
      den_r <= req.den;
      cnt_r <= CNT_W'(DATA_W);
    end else if (busy_r) begin
      rem_r <= take ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo_r <= {1'b0, quo_r[DATA_W-2:0], take};
      cnt_r <= cnt_r - CNT_W'(1);
    end else if (fix_r && neg_r) begin
      quo_r <= -quo_r;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
